// ===== src/ott_pkg.sv =====
// ----------------------------------------------------------------------------
// ott_pkg: shared types and constants of the one-shot timer table
// Holds the request and event codes, the entry layout and the register map.
// ----------------------------------------------------------------------------
package ott_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  // Request codes.
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_KILL = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  // Result codes.
  localparam logic [2:0] EV_ADDED    = 3'd0;
  localparam logic [2:0] EV_PRESENT  = 3'd1;
  localparam logic [2:0] EV_FULL     = 3'd2;
  localparam logic [2:0] EV_KILLED   = 3'd3;
  localparam logic [2:0] EV_NOTFOUND = 3'd4;
  localparam logic [2:0] EV_EXPIRED  = 3'd5;
  localparam logic [2:0] EV_NONE     = 3'd6;

  // Register map: one 32-bit register per word.
  localparam int         PADDR_W         = 3;
  localparam logic       REG_TICK_PERIOD = 1'b0;
  localparam logic [15:0] PERIOD_RESET   = 16'd100;

  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] timer;
    logic [31:0] remaining;
  } entry_t;

  typedef struct packed {
    logic        match;
    logic        gt;
    logic [31:0] diff;
  } alu_res_t;

endpackage

// ===== src/one_shot_timer_table.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_table: table of one-shot timers keyed by owner and timer id
// A request is taken only while idle; busy then stays high until its final
// result. The live entries are scanned one entry per cycle through the single
// read port of the table memory and the shared compare unit.
// Results are strobed for one cycle and the receiver cannot stall them.
// Reset empties the table and loads the tick period with 100.
// ----------------------------------------------------------------------------
module one_shot_timer_table #(
  parameter int TABLE_ENTRIES = ott_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [31:0]                 owner_id,
  input  logic [31:0]                 timer_id,
  input  logic [31:0]                 delay,
  output logic                        res_valid,
  output logic [2:0]                  event_res,
  output logic [31:0]                 owner_id_res,
  output logic [31:0]                 timer_id_res,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ott_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ott_pkg::*;

  // Index width covers the table; the counters can also hold the full size.
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  typedef enum logic {IDLE, SCAN} state_t;

  state_t           state;
  logic [15:0]      period;
  logic [CNT_W-1:0] count;     // Live entries form a packed prefix of the table.
  logic [CNT_W-1:0] rd_ptr;    // Next entry to read.
  logic [CNT_W-1:0] w_ptr;     // Next compaction slot for kill and tick.
  logic             p_vld;     // Read data of the previous cycle is a live entry.
  logic             found;
  logic [1:0]       op_q;
  logic [31:0]      owner_q;
  logic [31:0]      timer_q;
  logic [31:0]      delay_q;
  // An expired entry is held back one report so that the final one carries last.
  logic             hold_vld;
  logic [31:0]      hold_owner;
  logic [31:0]      hold_timer;

  logic             issue;
  logic             scan_done;
  logic             kill_skip;
  logic             cfg_write;
  logic             reg_sel;
  logic [31:0]      alu_a;
  alu_res_t         alu;
  entry_t           rd_data;
  entry_t           wr_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  assign busy   = (state != IDLE);
  assign pready = 1'b1;
  assign reg_sel   = (paddr[PADDR_W-1:2] == REG_TICK_PERIOD);
  assign cfg_write = psel && penable && pwrite && reg_sel;
  assign prdata    = reg_sel ? {16'b0, period} : 32'd0;

  // The scan reads one entry a cycle and handles it the cycle after, when the
  // registered read data arrives. The scan is over once the last read has been
  // handled. Compaction writes always land below the read pointer.
  always_comb begin
    issue     = (state == SCAN) && (rd_ptr < count);
    scan_done = (state == SCAN) && !p_vld && (rd_ptr >= count);
    // For a set the shared unit clamps the requested delay to the period;
    // otherwise it lowers the remaining time of the entry being handled.
    alu_a     = (op_q == OP_SET) ? delay_q : rd_data.remaining;
    kill_skip = alu.match && !found;

    wr_en   = 1'b0;
    wr_addr = w_ptr[IDX_W-1:0];
    wr_data = rd_data;
    if ((state == SCAN) && p_vld) begin
      case (op_q)
        OP_KILL: begin
          // Every entry but the first match moves down into the gap.
          wr_en = !kill_skip;
        end
        OP_TICK: begin
          wr_en             = alu.gt;
          wr_data.remaining = alu.diff;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    if (scan_done && (op_q == OP_SET) && !found && (count != FULL_COUNT)) begin
      wr_en             = 1'b1;
      wr_addr           = count[IDX_W-1:0];
      wr_data.owner     = owner_q;
      wr_data.timer     = timer_q;
      wr_data.remaining = alu.gt ? delay_q : {16'b0, period};
    end
  end

  ott_alu u_alu (
    .key_owner (owner_q),
    .key_timer (timer_q),
    .ent_owner (rd_data.owner),
    .ent_timer (rd_data.timer),
    .a         (alu_a),
    .period    (period),
    .res       (alu)
  );

  ott_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_ptr[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      period    <= PERIOD_RESET;
      count     <= '0;
      rd_ptr    <= '0;
      w_ptr     <= '0;
      p_vld     <= 1'b0;
      found     <= 1'b0;
      hold_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (cfg_write) begin
        period <= pwdata[15:0];
      end
      case (state)
        IDLE: begin
          // The unused request code is taken and dropped without a result.
          if (start && (op != OP_NONE)) begin
            op_q     <= op;
            owner_q  <= owner_id;
            timer_q  <= timer_id;
            delay_q  <= delay;
            rd_ptr   <= '0;
            w_ptr    <= '0;
            p_vld    <= 1'b0;
            found    <= 1'b0;
            hold_vld <= 1'b0;
            state    <= SCAN;
          end
        end
        SCAN: begin
          p_vld <= issue;
          if (issue) begin
            rd_ptr <= rd_ptr + 1'b1;
          end
          if (p_vld) begin
            case (op_q)
              OP_SET: begin
                if (alu.match) begin
                  found <= 1'b1;
                end
              end
              OP_KILL: begin
                if (kill_skip) begin
                  found <= 1'b1;
                end else begin
                  w_ptr <= w_ptr + 1'b1;
                end
              end
              OP_TICK: begin
                if (alu.gt) begin
                  w_ptr <= w_ptr + 1'b1;
                end else begin
                  if (hold_vld) begin
                    res_valid    <= 1'b1;
                    event_res    <= EV_EXPIRED;
                    owner_id_res <= hold_owner;
                    timer_id_res <= hold_timer;
                    last         <= 1'b0;
                  end
                  hold_vld   <= 1'b1;
                  hold_owner <= rd_data.owner;
                  hold_timer <= rd_data.timer;
                end
              end
              default: begin
                found <= found;
              end
            endcase
          end
          if (scan_done) begin
            state        <= IDLE;
            res_valid    <= 1'b1;
            last         <= 1'b1;
            owner_id_res <= owner_q;
            timer_id_res <= timer_q;
            case (op_q)
              OP_SET: begin
                if (found) begin
                  event_res <= EV_PRESENT;
                end else if (count == FULL_COUNT) begin
                  event_res <= EV_FULL;
                end else begin
                  event_res <= EV_ADDED;
                  count     <= count + 1'b1;
                end
              end
              OP_KILL: begin
                if (found) begin
                  event_res <= EV_KILLED;
                  count     <= count - 1'b1;
                end else begin
                  event_res <= EV_NOTFOUND;
                end
              end
              OP_TICK: begin
                count <= w_ptr;
                if (hold_vld) begin
                  event_res    <= EV_EXPIRED;
                  owner_id_res <= hold_owner;
                  timer_id_res <= hold_timer;
                end else begin
                  event_res    <= EV_NONE;
                  owner_id_res <= 32'd0;
                  timer_id_res <= 32'd0;
                end
              end
              default: begin
                event_res <= EV_NONE;
              end
            endcase
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The live count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("live entry count exceeds the table size");

  // The compaction pointer never passes the read pointer.
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (w_ptr <= rd_ptr))
    else $error("compaction pointer passed the read pointer");

  // Only the final result of a request leaves the block idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (last == !busy))
    else $error("last flag disagrees with the sequencer state");

  // A real request starts a scan.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op != OP_NONE)) |=> busy)
    else $error("accepted request did not start a scan");

endmodule

// ===== src/ott_mem.sv =====
// ----------------------------------------------------------------------------
// ott_mem: timer entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ott_mem #(
  parameter int DEPTH = ott_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W = 4
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  ott_pkg::entry_t      wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output ott_pkg::entry_t      rd_data
);
  import ott_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/ott_alu.sv =====
// ----------------------------------------------------------------------------
// ott_alu: shared key compare and period subtract unit
// Matches an entry against the request key and compares a time to the period.
// ----------------------------------------------------------------------------
module ott_alu (
  input  logic [31:0]        key_owner,
  input  logic [31:0]        key_timer,
  input  logic [31:0]        ent_owner,
  input  logic [31:0]        ent_timer,
  input  logic [31:0]        a,
  input  logic [15:0]        period,
  output ott_pkg::alu_res_t  res
);
  import ott_pkg::*;

  logic [31:0] per_ext;

  always_comb begin
    per_ext = {16'b0, period};
    // An owner of zero never matches, so testing the key side is enough.
    res.match = (key_owner != 32'd0) && (ent_owner == key_owner) &&
                (ent_timer == key_timer);
    res.gt    = a > per_ext;
    res.diff  = a - per_ext;
  end

endmodule

// ===== tb/sv/tb_one_shot_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_shot_timer_table: self-checking bench for the one-shot timer table
// A queue of requests feeds a clocked driver. A software copy of the timer
// table predicts the events that each accepted request causes. A clocked
// monitor compares every strobed event, field by field, with the oldest
// prediction. The run walks through several tick periods, the extremes
// among them, and three sender idling regimes.
// ----------------------------------------------------------------------------
module tb_one_shot_timer_table;
  import ott_pkg::*;

  localparam int TABLE_DEPTH = TABLE_ENTRIES_DEF;
  localparam int RANDOM_PER_PHASE = 50;
  localparam int NUM_PHASES = 6;
  // A request scans no more than the table, so this idle wait is ample
  // for an ignored request to finish before the period is rewritten.
  localparam int SETTLE_CYCLES = 40;
  localparam int RESULT_WAIT_LIMIT = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [PADDR_W-1:0] TICK_PERIOD_ADDR = PADDR_W'(4 * REG_TICK_PERIOD);

  typedef struct {
    logic [1:0]  op;
    logic [31:0] owner;
    logic [31:0] timer;
    logic [31:0] delay;
  } timer_request_t;

  typedef struct {
    logic [2:0]  ev;
    logic [31:0] owner;
    logic [31:0] timer;
    logic        last;
  } timer_event_t;

  // Block ports. Every input holds a known value from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = OP_NONE;
  logic [31:0] owner_id = '0;
  logic [31:0] timer_id = '0;
  logic [31:0] delay = '0;
  logic        res_valid;
  logic [2:0]  event_res;
  logic [31:0] owner_id_res;
  logic [31:0] timer_id_res;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Requests waiting to be driven, and events waiting to be seen.
  timer_request_t pending_requests[$];
  timer_event_t   expected_events[$];
  timer_request_t current_request;
  logic [63:0]    recent_keys[$];

  // Software copy of the table, kept packed in insertion order like the block.
  logic [31:0] live_owner[TABLE_DEPTH];
  logic [31:0] live_timer[TABLE_DEPTH];
  logic [31:0] live_remaining[TABLE_DEPTH];
  int          live_count = 0;
  logic [15:0] period_shadow = PERIOD_RESET;

  int unsigned sender_gap_pct = 35;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  one_shot_timer_table u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .owner_id(owner_id), .timer_id(timer_id), .delay(delay),
    .res_valid(res_valid), .event_res(event_res), .owner_id_res(owner_id_res),
    .timer_id_res(timer_id_res), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Returns the index of the first live entry that a set or kill with this
  // key matches. Entries owned by owner zero never match.
  function automatic int find_live(input logic [31:0] owner, input logic [31:0] timer);
    for (int i = 0; i < live_count; i++) begin
      if (live_owner[i] != 0 && live_owner[i] == owner && live_timer[i] == timer)
        return i;
    end
    return -1;
  endfunction

  // Takes one entry out and closes up the entries behind it.
  function automatic void remove_entry(input int idx);
    for (int i = idx; i + 1 < live_count; i++) begin
      live_owner[i] = live_owner[i + 1];
      live_timer[i] = live_timer[i + 1];
      live_remaining[i] = live_remaining[i + 1];
    end
    live_count--;
  endfunction

  function automatic void push_event(input logic [2:0] ev, input logic [31:0] owner,
                                     input logic [31:0] timer, input logic is_last);
    timer_event_t e;
    e.ev = ev;
    e.owner = owner;
    e.timer = timer;
    e.last = is_last;
    expected_events.push_back(e);
  endfunction

  // Applies one accepted request to the table copy and queues its events.
  function automatic void predict_request(input timer_request_t r);
    logic [31:0] per;
    int idx;
    int i;
    int expired;
    per = {16'd0, period_shadow};
    case (r.op)
      OP_SET: begin
        idx = find_live(r.owner, r.timer);
        if (idx >= 0) begin
          push_event(EV_PRESENT, r.owner, r.timer, 1'b1);
        end else if (live_count >= TABLE_DEPTH) begin
          push_event(EV_FULL, r.owner, r.timer, 1'b1);
        end else begin
          // A delay shorter than one tick is raised to one tick.
          live_owner[live_count] = r.owner;
          live_timer[live_count] = r.timer;
          live_remaining[live_count] = (r.delay < per) ? per : r.delay;
          live_count++;
          push_event(EV_ADDED, r.owner, r.timer, 1'b1);
        end
      end
      OP_KILL: begin
        idx = find_live(r.owner, r.timer);
        if (idx >= 0) begin
          remove_entry(idx);
          push_event(EV_KILLED, r.owner, r.timer, 1'b1);
        end else begin
          push_event(EV_NOTFOUND, r.owner, r.timer, 1'b1);
        end
      end
      OP_TICK: begin
        // The entry that slides into a freed slot is visited next, so no
        // entry is skipped after an expiry.
        i = 0;
        expired = 0;
        while (i < live_count) begin
          if (live_remaining[i] > per) begin
            live_remaining[i] -= per;
            i++;
          end else begin
            push_event(EV_EXPIRED, live_owner[i], live_timer[i], 1'b0);
            expired++;
            remove_entry(i);
          end
        end
        if (expired == 0)
          push_event(EV_NONE, '0, '0, 1'b1);
        else
          expected_events[expected_events.size() - 1].last = 1'b1;
      end
      default: begin
        // The unused code is ignored by the block.
      end
    endcase
  endfunction

  // Driver: the presented request is accepted at an edge where start is high
  // and busy is low. After that, or while nothing is presented, the next
  // request may go out unless the sender chooses to idle this cycle.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        predict_request(current_request);
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
          current_request = pending_requests.pop_front();
          start <= 1'b1;
          op <= current_request.op;
          owner_id <= current_request.owner;
          timer_id <= current_request.timer;
          delay <= current_request.delay;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed event is checked against the oldest prediction.
  always @(posedge clk) begin
    timer_event_t want;
    if (!rst && res_valid) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event with nothing expected", {29'd0, event_res}, '0);
      end else begin
        want = expected_events.pop_front();
        if (event_res !== want.ev)
          report_mismatch("event_res", {29'd0, event_res}, {29'd0, want.ev});
        if (owner_id_res !== want.owner)
          report_mismatch("owner_id_res", owner_id_res, want.owner);
        if (timer_id_res !== want.timer)
          report_mismatch("timer_id_res", timer_id_res, want.timer);
        if (last !== want.last)
          report_mismatch("last", {31'd0, last}, {31'd0, want.last});
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_request(input logic [1:0] req_op, input logic [31:0] owner,
                              input logic [31:0] timer, input logic [31:0] dly);
    timer_request_t r;
    r.op = req_op;
    r.owner = owner;
    r.timer = timer;
    r.delay = dly;
    pending_requests.push_back(r);
  endtask

  // Writes the tick period through the register port, then reads it back.
  task automatic set_tick_period(input logic [15:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TICK_PERIOD_ADDR;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    period_shadow = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[15:0] !== value)
      report_mismatch("tick_period readback", {16'd0, readback[15:0]}, {16'd0, value});
  endtask

  // Waits until every queued request is taken and every predicted event has
  // come, then lets the block finish any ignored request.
  task automatic settle_block();
    int waited;
    while (pending_requests.size() != 0 || start) @(posedge clk);
    waited = 0;
    while (expected_events.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_events.size() != 0) begin
      report_mismatch("events never delivered", expected_events.size(), '0);
      expected_events.delete();
    end
  endtask

  // Delays cluster around whole multiples of the period so that expiries
  // land on exact boundaries; a few are tiny, huge or fully random.
  function automatic logic [31:0] pick_delay(input logic [15:0] per);
    int unsigned r;
    logic [31:0] base;
    r = $urandom_range(0, 99);
    base = per * $urandom_range(1, 4);
    if (r < 10) return '0;
    if (r < 25) return $urandom_range(0, per);
    if (r < 70) begin
      case ($urandom_range(0, 2))
        0: return (base == 0) ? base : base - 1;
        1: return base;
        default: return base + 1;
      endcase
    end
    if (r < 90) return $urandom_range(0, 8 * per + 1);
    return $urandom();
  endfunction

  // Keys come mostly from a small space, so sets collide and kills hit.
  function automatic void pick_key(output logic [31:0] owner, output logic [31:0] timer);
    int unsigned r;
    logic [63:0] key;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      owner = $urandom_range(0, 5);
      timer = $urandom_range(0, 3);
    end else if (r < 85 && recent_keys.size() != 0) begin
      key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      owner = key[63:32];
      timer = key[31:0];
    end else begin
      owner = $urandom();
      timer = $urandom();
    end
  endfunction

  function automatic void remember_key(input logic [31:0] owner, input logic [31:0] timer);
    recent_keys.push_back({owner, timer});
    if (recent_keys.size() > 16) void'(recent_keys.pop_front());
  endfunction

  initial begin
    logic [15:0] phase_period[NUM_PHASES];
    int unsigned phase_gap[NUM_PHASES];
    logic [31:0] o;
    logic [31:0] t;
    int made;
    int unsigned r;

    // The first two phases idle the sender lightly, the next two heavily,
    // and the last two not at all. Periods include both ends of the
    // register range and zero, where only entries with no time left expire.
    phase_period = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 400)),
                     16'($urandom()), 16'd100};
    phase_gap = '{35, 35, 81, 81, 0, 0};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset period of 100.
    push_request(OP_TICK, 32'h1, 32'h2, 32'h3);                  // tick on empty table
    push_request(OP_SET, 32'h0, 32'h5, 32'h0);                   // owner zero, tiny delay
    push_request(OP_SET, 32'h0, 32'h5, 32'h0);                   // owner zero never matches
    push_request(OP_KILL, 32'h0, 32'h5, 32'h0);                  // so a kill misses it
    push_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);   // already present
    push_request(OP_SET, 32'h1, 32'h0, 32'd100);                 // exactly one period
    push_request(OP_SET, 32'h1, 32'h1, 32'd101);                 // one ms past a period
    push_request(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(OP_KILL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the table, overflow it, then expire every entry in one tick.
    for (int i = 0; i < TABLE_DEPTH - 1; i++)
      push_request(OP_SET, 32'h10 + i, 32'(i), 32'h0);
    push_request(OP_SET, 32'h8000_0000, 32'h7, 32'h5);
    push_request(OP_TICK, 32'h0, 32'h0, 32'h0);
    settle_block();

    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_gap_pct = phase_gap[p];
      set_tick_period(phase_period[p]);
      made = 0;
      while (made < RANDOM_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          // A burst of fresh keys overruns the table whatever it holds.
          for (int i = 0; i <= TABLE_DEPTH; i++)
            push_request(OP_SET, $urandom(), $urandom(), pick_delay(phase_period[p]));
          made += TABLE_DEPTH + 1;
        end else if (r < 45) begin
          pick_key(o, t);
          push_request(OP_SET, o, t, pick_delay(phase_period[p]));
          remember_key(o, t);
          made++;
        end else if (r < 68) begin
          pick_key(o, t);
          push_request(OP_KILL, o, t, $urandom());
          made++;
        end else if (r < 95) begin
          push_request(OP_TICK, $urandom(), $urandom(), $urandom());
          made++;
        end else begin
          push_request(OP_NONE, $urandom(), $urandom(), $urandom());
        end
      end
      settle_block();
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
